/* design/s256h_pkg.sv */
// shared constants and functions for the sha-256 byte stream hasher
package s256h_pkg;

    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // initial hash value for word k
    function automatic word_t init_hash(input logic [2:0] k);
        word_t r;
        case (k)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // round constant for round t
    function automatic word_t round_k(input logic [5:0] t);
        word_t r;
        case (t)
            6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
            6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
            6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
            6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
            6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
            6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
            6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
            6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
            6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
            6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
            6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
            6'd63: r = 32'hc67178f2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* design/sha256_byte_stream_hasher_unit.sv */
// sha-256 hasher over a byte stream with a one-round-per-cycle compression unit
// a byte is taken while idle; a byte that fills a block then goes through the load,
// round and chaining-update phases, and no new byte is taken until they are done
// end of message: pad writes up to the block end, then load, rounds and chaining
// update per padded block (1 or 2 blocks), then 8 digest words
// reset: synchronous active-low aresetn restores initial hash, zero length, idle
module sha256_byte_stream_hasher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [0] carries_byte, [1] end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_ROUND= 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    s256h_pkg::word_t chain_reg [8];
    s256h_pkg::word_t v_reg [8];
    s256h_pkg::word_t w_reg [16];
    logic [6:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic        final_reg;   // end requested, padding pending or in progress
    logic        lenin_reg;   // current block carries the length
    logic [2:0]  oidx_reg;
    logic        markdone_reg; // pad marker already written

    // byte-wide block memory; read one word at a time during load
    logic [7:0]  mem_b0 [16];
    logic [7:0]  mem_b1 [16];
    logic [7:0]  mem_b2 [16];
    logic [7:0]  mem_b3 [16];

    logic        accept;
    logic [5:0]  wr_pos;
    logic [7:0]  wr_byte;
    logic        wr_en;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'd0, oidx_reg, chain_reg[oidx_reg]};
    assign m_tlast  = (oidx_reg == 3'd7);

    // padding byte selection: pad marker, zeros, then length bytes
    logic [7:0] pad_byte;
    logic [5:0] pos6;
    assign pos6 = fill_reg[5:0];
    always_comb begin
        if (!markdone_reg)
            pad_byte = s256h_pkg::PAD_BYTE;
        else if (pos6 >= s256h_pkg::LEN_POS && lenin_reg)
            pad_byte = bits_reg[6'd63 - {pos6[2:0], 3'd0} -: 8];
        else
            pad_byte = 8'd0;
    end

    // memory write port
    always_comb begin
        wr_en   = 1'b0;
        wr_pos  = pos6;
        wr_byte = s_tdata;
        if (accept && s_tuser[0]) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_PAD) begin
            wr_en   = 1'b1;
            wr_byte = pad_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (wr_pos[1:0])
                2'd0: mem_b0[wr_pos[5:2]] <= wr_byte;
                2'd1: mem_b1[wr_pos[5:2]] <= wr_byte;
                2'd2: mem_b2[wr_pos[5:2]] <= wr_byte;
                default: mem_b3[wr_pos[5:2]] <= wr_byte;
            endcase
        end
    end

    // registered word read for schedule load
    logic [31:0] rd_word_reg;
    always_ff @(posedge aclk) begin
        rd_word_reg <= {mem_b0[round_reg[3:0]], mem_b1[round_reg[3:0]],
                        mem_b2[round_reg[3:0]], mem_b3[round_reg[3:0]]};
    end

    // shared round unit
    s256h_pkg::word_t sig0, sig1, wnew, wt, t1, t2, s1, s0, ch, mj;
    always_comb begin
        sig0 = s256h_pkg::ror(w_reg[1], 7) ^ s256h_pkg::ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1 = s256h_pkg::ror(w_reg[14], 17) ^ s256h_pkg::ror(w_reg[14], 19)
               ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + sig0 + w_reg[9] + sig1;
        wt   = (round_reg < 6'd16) ? w_reg[0] : wnew;
        s1   = s256h_pkg::ror(v_reg[4], 6) ^ s256h_pkg::ror(v_reg[4], 11)
               ^ s256h_pkg::ror(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + s1 + ch + s256h_pkg::round_k(round_reg) + wt;
        s0   = s256h_pkg::ror(v_reg[0], 2) ^ s256h_pkg::ror(v_reg[0], 13)
               ^ s256h_pkg::ror(v_reg[0], 22);
        mj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = s0 + mj;
    end

    // next-state logic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] && pos6 == 6'd63) state_next = ST_LOAD;
                    else if (s_tuser[1])             state_next = ST_PAD;
                end
            end
            ST_PAD:   if (pos6 == 6'd63) state_next = ST_LOAD;
            ST_LOAD:  if (round_reg == 6'd16) state_next = ST_ROUND;
            ST_ROUND: if (round_reg == 6'd63) state_next = ST_ADD;
            ST_ADD: begin
                if (!final_reg)     state_next = ST_IDLE;
                else if (lenin_reg) state_next = ST_OUT;
                else                state_next = ST_PAD;
            end
            ST_OUT:   if (m_tready && oidx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= 7'd0;
            bits_reg  <= 64'd0;
            round_reg <= 6'd0;
            final_reg <= 1'b0;
            lenin_reg <= 1'b0;
            oidx_reg  <= 3'd0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= s256h_pkg::init_hash(3'(i));
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    round_reg <= 6'd0;
                    if (accept) begin
                        if (s_tuser[0]) begin
                            fill_reg <= {1'b0, pos6 + 6'd1};
                            bits_reg <= bits_reg + 64'd8;
                        end
                        final_reg <= s_tuser[1];
                        lenin_reg <= 1'b0;
                        if (s_tuser[1] && !(s_tuser[0] && pos6 == 6'd63)) begin
                            // pad marker is written in first pad cycle
                            if (s_tuser[0]) fill_reg <= {1'b0, pos6 + 6'd1};
                            lenin_reg <= s_tuser[0] ? (pos6 + 6'd1 < 6'd56)
                                                    : (pos6 < 6'd56);
                        end
                    end
                end
                ST_PAD: begin
                    round_reg <= 6'd0;
                    fill_reg  <= {1'b0, pos6 + 6'd1};
                end
                ST_LOAD: begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg != 6'd0) begin
                        for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                        w_reg[15] <= rd_word_reg;
                    end
                    if (round_reg == 6'd16) round_reg <= 6'd0;
                    for (int i = 0; i < 8; i++) v_reg[i] <= chain_reg[i];
                end
                ST_ROUND: begin
                    round_reg <= round_reg + 6'd1;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= (round_reg < 6'd16) ? w_reg[0] : wnew;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                ST_ADD: begin
                    round_reg <= 6'd0;
                    fill_reg  <= 7'd0;
                    for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + v_reg[i];
                    if (final_reg && !lenin_reg) begin
                        // next block is padding; marker already placed if needed
                        lenin_reg <= 1'b1;
                    end
                    oidx_reg <= 3'd0;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= s256h_pkg::init_hash(3'(i));
                            bits_reg  <= 64'd0;
                            fill_reg  <= 7'd0;
                            final_reg <= 1'b0;
                            lenin_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // pad marker tracking: set once the 0x80 byte lands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            markdone_reg <= 1'b0;
        end else if (state_reg == ST_IDLE) begin
            markdone_reg <= 1'b0;
        end else if (state_reg == ST_PAD) begin
            markdone_reg <= 1'b1;
        end
    end

    // digest words are never offered while the input side is ready
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> !s_tready)
        else $error("output and input both active");
    // round counter stays in range of the load phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (round_reg <= 6'd16))
        else $error("load counter overrun");
    // a finished round sweep is followed by the chaining add
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("missed chaining add");
    // last word retires into idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("no return to idle after digest");

endmodule

/* test/sha256_byte_stream_hasher_unit_tb.sv */
// testbench for the sha-256 byte stream hasher: random stream, digest predictor
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_unit_tb;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       end_of_message;
    } request_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_out_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    request_t    pending_requests[$];
    digest_out_t digest_queue[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          pause_sender;
    bit          calm_phase;
    bit          req_taken;

    // message lengths: odd entries end with a separate empty end item
    int msg_len_list[6] = '{55, 56, 64, 63, 9, 1};

    // predictor state
    logic [31:0] hash_state[8];
    logic [7:0]  msg_block[64];
    int          fill_count;
    logic [63:0] bit_count;

    sha256_byte_stream_hasher_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock, period 4 ns
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one sha-256 compression of msg_block into hash_state
    task automatic compress_block();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] rc[64];
        rc = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        v = hash_state;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rc[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            hash_state[k] += v[k];
    endtask

    task automatic restart_hash();
        for (int k = 0; k < 8; k++)
            hash_state[k] = s256h_pkg::init_hash(k[2:0]);
        fill_count = 0;
        bit_count  = '0;
    endtask

    // predict the digest words caused by one accepted request
    task automatic predict_digest(request_t r);
        digest_out_t d;
        if (r.carries_byte) begin
            msg_block[fill_count] = r.data_byte;
            fill_count++;
            bit_count += 64'd8;
            if (fill_count == 64) begin
                compress_block();
                fill_count = 0;
            end
        end
        if (r.end_of_message) begin
            msg_block[fill_count] = s256h_pkg::PAD_BYTE;
            fill_count++;
            if (fill_count > 56) begin
                while (fill_count < 64) begin
                    msg_block[fill_count] = 8'h00;
                    fill_count++;
                end
                compress_block();
                fill_count = 0;
            end
            while (fill_count < 56) begin
                msg_block[fill_count] = 8'h00;
                fill_count++;
            end
            for (int k = 0; k < 8; k++)
                msg_block[56+k] = bit_count[63-8*k -: 8];
            compress_block();
            for (int k = 0; k < 8; k++) begin
                d.digest_word = hash_state[k];
                d.word_index  = k[2:0];
                d.last_word   = (k == 7);
                digest_queue.push_back(d);
            end
            restart_hash();
        end
    endtask

    function automatic bit idle_now();
        return !calm_phase && ($urandom_range(99) < 12);
    endfunction

    // driver: present requests at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || req_taken) begin
                if (pending_requests.size() > 0 && !pause_sender && !idle_now()) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_requests[0].data_byte;
                    s_tuser  <= {pending_requests[0].end_of_message,
                                 pending_requests[0].carries_byte};
                    void'(pending_requests.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !idle_now();
        end
    end

    // request acceptance feeds the predictor
    always @(posedge aclk) begin
        req_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            predict_digest('{s_tdata, s_tuser[0], s_tuser[1]});
    end

    // monitor: compare each digest word against the oldest expectation
    always @(posedge aclk) begin
        digest_out_t exp_d;
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h idx %0d last %b",
                             m_tdata[31:0], m_tdata[34:32], m_tlast);
            end else begin
                exp_d = digest_queue.pop_front();
                if (m_tdata[31:0] !== exp_d.digest_word || m_tdata[34:32] !== exp_d.word_index
                        || m_tlast !== exp_d.last_word || m_tdata[39:35] !== 5'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                                 exp_d.digest_word, exp_d.word_index, exp_d.last_word,
                                 m_tdata[31:0], m_tdata[34:32], m_tlast);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_request(logic [7:0] b, bit carries, bit eom);
        request_t r;
        r.data_byte      = b;
        r.carries_byte   = carries;
        r.end_of_message = eom;
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_tvalid || digest_queue.size() > 0)
            @(posedge aclk);
    endtask

    // stimulus
    initial begin
        int msg_len;
        int msgs;
        aresetn      = 1'b0;
        pause_sender = 1'b0;
        calm_phase   = 1'b0;
        restart_hash();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty message, idle item, extreme bytes, end with byte
        add_request(8'h00, 1'b0, 1'b1);
        add_request(8'h5a, 1'b0, 1'b0);
        add_request(8'hff, 1'b1, 1'b0);
        add_request(8'h00, 1'b1, 1'b0);
        add_request(8'haa, 1'b1, 1'b1);
        add_request(8'h55, 1'b1, 1'b0);
        add_request(8'h00, 1'b0, 1'b1);

        // sender holds off until every digest word is back
        while (pending_requests.size() > 0)
            @(posedge aclk);
        pause_sender = 1'b1;
        wait_drained();
        pause_sender = 1'b0;

        // directed lengths around the padding boundaries, no idling
        calm_phase = 1'b1;
        foreach (msg_len_list[i]) begin
            for (int j = 0; j < msg_len_list[i]; j++)
                add_request(8'($urandom_range(255)), 1'b1,
                            (j == msg_len_list[i] - 1) && (i % 2 == 0));
            if (i % 2 == 1)
                add_request(8'h00, 1'b0, 1'b1);
        end
        wait_drained();
        calm_phase = 1'b0;

        // random messages, mostly short, a few noise items, random idling
        msgs = 0;
        while (msgs < 4) begin
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(140) : $urandom_range(20);
            for (int j = 0; j < msg_len; j++) begin
                if ($urandom_range(9) == 0)
                    add_request(8'($urandom_range(255)), 1'b0, 1'b0);
                add_request(8'($urandom_range(255)), 1'b1, 1'b0);
            end
            add_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            msgs++;
        end
        wait_drained();
        repeat (200) @(posedge aclk);

        if (mismatches == 0 && digest_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sha256_byte_stream_hasher_unit.f */
design/s256h_pkg.sv
design/sha256_byte_stream_hasher_unit.sv
test/sha256_byte_stream_hasher_unit_tb.sv
